// ===== sv/isu_pkg.sv =====
// Shared constants and codes for the Ising Metropolis spin update core.
package isu_pkg;

    localparam int ROWS_DEF  = 32;
    localparam int COLS_DEF  = 32;

    localparam int IN_IDX_W  = 5;
    localparam int RND_W     = 16;
    localparam int DE_W      = 5;
    localparam int BAL_OUT_W = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DE4 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DE8 = 1'b1;

    localparam logic [CFG_W-1:0] TH4_RST = 16'd1200;
    localparam logic [CFG_W-1:0] TH8_RST = 16'd22;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_VISIT = 1'b1;

    localparam logic signed [DE_W-1:0] DE_FOUR = 5'sd4;

    // Row read ports of the lattice store.
    localparam int NPORT    = 3;
    localparam int PORT_UP  = 0;
    localparam int PORT_MID = 1;
    localparam int PORT_DN  = 2;

endpackage

// ===== sv/isu_lattice.sv =====
// Spin lattice store: three row-wide copies, per-row valid bits and write bypass.
module isu_lattice import isu_pkg::*; #(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_rd_en,
    input  logic [NPORT-1:0][$clog2(ROWS)-1:0]   i_rd_row,
    input  logic                                 i_wr_en,
    input  logic [$clog2(ROWS)-1:0]              i_wr_row,
    input  logic [COLS-1:0]                      i_wr_data,
    output logic [NPORT-1:0][COLS-1:0]           o_row
);

    logic [ROWS-1:0] r_row_vld;
    logic [COLS-1:0] r_byp_data;

    // A row never written reads as all spins up.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_wr_en) begin
            r_row_vld[i_wr_row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp_data <= i_wr_data;
        end
    end

    for (genvar k = 0; k < NPORT; k++) begin : g_copy
        logic [COLS-1:0] r_mem [ROWS];
        logic [COLS-1:0] r_q;
        logic            r_q_vld;
        logic            r_hit;

        always_ff @(posedge i_clk) begin
            if (i_wr_en) begin
                r_mem[i_wr_row] <= i_wr_data;
            end
            if (i_rd_en) begin
                r_q <= r_mem[i_rd_row[k]];
            end
        end

        // A write at the same edge as the read is not seen by the array read,
        // so the written row is taken from the bypass register instead.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_vld <= 1'b0;
                r_hit   <= 1'b0;
            end else if (i_rd_en) begin
                r_q_vld <= r_row_vld[i_rd_row[k]];
                r_hit   <= i_wr_en && (i_wr_row == i_rd_row[k]);
            end
        end

        assign o_row[k] = r_hit ? r_byp_data : (r_q_vld ? r_q : '1);
    end

endmodule

// ===== sv/ising_metropolis_spin_update_core.sv =====
// Ising lattice core with single-site Metropolis update and running bond balance.
// A result passes the stage-1 register and then the result register after its input beat is accepted.
// Throughput: one beat per cycle while the result is not stalled; the lattice row reads and the row write
// of the previous beat share the same edge, resolved by a one-row bypass.
// Reset (synchronous, active low): all spins up, balance 2*ROWS*COLS,
// thresholds 1200 and 22; no clearing pass, per-row valid bits are cleared.
module ising_metropolis_spin_update_core import isu_pkg::*; #(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]             i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_req_type,
    input  logic [IN_IDX_W-1:0]          i_row,
    input  logic [IN_IDX_W-1:0]          i_col,
    input  logic                         i_spin_value,
    input  logic [RND_W-1:0]             i_random_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_spin_after,
    output logic                         o_flipped,
    output logic signed [DE_W-1:0]       o_energy_change,
    output logic signed [BAL_OUT_W-1:0]  o_bond_balance
);

    localparam int RW       = $clog2(ROWS);
    localparam int CW       = $clog2(COLS);
    localparam int BAL_FULL = $clog2(2 * ROWS * COLS + 1) + 1;
    localparam int BAL_W    = (BAL_FULL > BAL_OUT_W) ? BAL_FULL : BAL_OUT_W;
    localparam int IN_SPAN  = 2 ** IN_IDX_W;

    // Index reduction tables, filled at elaboration.
    logic [RW-1:0] row_mod [IN_SPAN];
    logic [CW-1:0] col_mod [IN_SPAN];

    for (genvar v = 0; v < IN_SPAN; v++) begin : g_mod
        assign row_mod[v] = RW'(v % ROWS);
        assign col_mod[v] = CW'(v % COLS);
    end

    logic [RW-1:0]             in_row;
    logic [CW-1:0]             in_col;
    logic [CW-1:0]             in_lf;
    logic [CW-1:0]             in_rt;
    logic [NPORT-1:0][RW-1:0]  rd_row;
    logic [NPORT-1:0][COLS-1:0] lat_row;
    logic                      in_acc;
    logic                      s1_adv;

    logic                      r_s1_vld;
    logic                      r_s1_req;
    logic [RW-1:0]             r_s1_row;
    logic [CW-1:0]             r_s1_col;
    logic [CW-1:0]             r_s1_lf;
    logic [CW-1:0]             r_s1_rt;
    logic                      r_s1_spin;
    logic [RND_W-1:0]          r_s1_rnd;

    logic [CFG_W-1:0]          r_th4;
    logic [CFG_W-1:0]          r_th8;

    logic                      r_out_vld;
    logic                      r_out_spin;
    logic                      r_out_flip;
    logic signed [DE_W-1:0]    r_out_de;
    logic signed [BAL_W-1:0]   r_bal;

    logic [COLS-1:0]           cur_row;
    logic                      s_old;
    logic [2:0]                up_cnt;
    logic signed [DE_W:0]      de_up;
    logic signed [DE_W:0]      de_wide;
    logic signed [DE_W-1:0]    de;
    logic                      accept;
    logic                      n_flip;
    logic                      n_spin;
    logic signed [DE_W-1:0]    n_de;
    logic signed [BAL_W-1:0]   n_bal;
    logic [COLS-1:0]           wr_data;

    assign in_row = row_mod[i_row];
    assign in_col = col_mod[i_col];
    assign in_lf  = (in_col == '0) ? CW'(COLS - 1) : in_col - CW'(1);
    assign in_rt  = (in_col == CW'(COLS - 1)) ? '0 : in_col + CW'(1);

    assign rd_row[PORT_UP]  = (in_row == '0) ? RW'(ROWS - 1) : in_row - RW'(1);
    assign rd_row[PORT_MID] = in_row;
    assign rd_row[PORT_DN]  = (in_row == RW'(ROWS - 1)) ? '0 : in_row + RW'(1);

    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    isu_lattice #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_lattice (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_row  (rd_row),
        .i_wr_en   (s1_adv),
        .i_wr_row  (r_s1_row),
        .i_wr_data (wr_data),
        .o_row     (lat_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_th4 <= TH4_RST;
            r_th8 <= TH8_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DE4: r_th4 <= i_cfg_wdata;
                CFG_DE8: r_th8 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_req  <= i_req_type;
            r_s1_row  <= in_row;
            r_s1_col  <= in_col;
            r_s1_lf   <= in_lf;
            r_s1_rt   <= in_rt;
            r_s1_spin <= i_spin_value;
            r_s1_rnd  <= i_random_value;
        end
    end

    // Flip energy: with n up neighbours the sum is 2n-4, so dE = +-(4n-8).
    assign cur_row = lat_row[PORT_MID];
    assign s_old   = cur_row[r_s1_col];
    assign up_cnt  = {2'b00, lat_row[PORT_UP][r_s1_col]} + {2'b00, lat_row[PORT_DN][r_s1_col]}
                   + {2'b00, cur_row[r_s1_lf]} + {2'b00, cur_row[r_s1_rt]};
    assign de_up   = $signed({1'b0, up_cnt, 2'b00}) - (DE_W+1)'(8);
    assign de_wide = s_old ? de_up : -de_up;
    assign de      = de_wide[DE_W-1:0];

    always_comb begin
        if (de[DE_W-1] || (de == '0)) begin
            accept = 1'b1;
        end else if (de == DE_FOUR) begin
            accept = r_s1_rnd < r_th4;
        end else begin
            accept = r_s1_rnd < r_th8;
        end
    end

    // A changed spin moves the balance by -dE for loads and visits alike.
    assign n_flip = (r_s1_req == REQ_LOAD) ? (r_s1_spin != s_old) : accept;
    assign n_spin = n_flip ? ~s_old : s_old;
    assign n_de   = (r_s1_req == REQ_VISIT) ? de : '0;
    assign n_bal  = n_flip ? r_bal - {{(BAL_W-DE_W){de[DE_W-1]}}, de} : r_bal;

    always_comb begin
        wr_data           = cur_row;
        wr_data[r_s1_col] = n_spin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_bal     <= BAL_W'(2 * ROWS * COLS);
        end else begin
            if (s1_adv) begin
                r_out_vld <= 1'b1;
                r_bal     <= n_bal;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_spin <= n_spin;
            r_out_flip <= n_flip;
            r_out_de   <= n_de;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_spin_after    = r_out_spin;
    assign o_flipped       = r_out_flip;
    assign o_energy_change = r_out_de;
    assign o_bond_balance  = r_bal[BAL_OUT_W-1:0];

endmodule

// ===== sv/isu_checker.sv =====
// Port-level checks for the Ising spin update core, bound to the top level.
module isu_checker import isu_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_in_ready,
    input  logic                         o_out_valid,
    input  logic                         i_out_ready,
    input  logic                         o_spin_after,
    input  logic                         o_flipped,
    input  logic signed [DE_W-1:0]       o_energy_change,
    input  logic signed [BAL_OUT_W-1:0]  o_bond_balance
);

    a_rst_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result beat valid right after reset");

    // An empty result register always lets the next input beat in.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready while result register is empty");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_spin_after)
            && $stable(o_flipped) && $stable(o_energy_change) && $stable(o_bond_balance))
        else $error("stalled result beat changed");

    // Energy lowering flips are always taken.
    a_negative_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_energy_change[DE_W-1] |-> o_flipped)
        else $error("negative flip energy without a flip");

    a_energy_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_energy_change == -5'sd8) || (o_energy_change == -5'sd4)
            || (o_energy_change == 5'sd0) || (o_energy_change == 5'sd4)
            || (o_energy_change == 5'sd8))
        else $error("flip energy outside the possible set");

endmodule

bind ising_metropolis_spin_update_core isu_checker u_isu_checker (.*);
